@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset too
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/alb_pkg.sv @@
// Shared types and constants for the ambient light brightness filter.
// No dependencies.
`default_nettype none

package alb_pkg;

    localparam int SAMPLE_W = 12;
    localparam int STEP_W   = 12;
    localparam int BRIGHT_W = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int SAMPLE_BITS_DEFAULT = 12;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE_RESET = 12'd3300;
    localparam logic [STEP_W-1:0]   STEP_RESET       = 12'd16;
    localparam logic [BRIGHT_W-1:0] BASE_RESET       = 8'd10;

    typedef enum logic [1:0] {
        REG_FULL_SCALE = 2'd0,
        REG_STEP       = 2'd1,
        REG_BASE       = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] full_scale;
        logic [STEP_W-1:0]   step;
        logic [BRIGHT_W-1:0] base;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/core/alb_serial_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses no package; zero divisor yields an all-ones quotient.
`default_nettype none

module alb_serial_div #(
    parameter int W  = 17,
    parameter int DW = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [W-1:0]  i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [W-1:0]       o_quot
);

    localparam int CNW = $clog2(W + 1);

    logic [CNW-1:0] r_cnt;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_div;
    logic [W-1:0]   r_quot;
    logic           r_done;

    logic [DW:0] n_trial;
    logic [DW:0] n_diff;
    logic        n_bit;

    always_comb begin
        n_trial = {r_rem, r_quot[W-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_bit   = (n_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= CNW'(W);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quot <= i_dividend;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_rem  <= n_bit ? n_diff[DW-1:0] : n_trial[DW-1:0];
                r_quot <= {r_quot[W-2:0], n_bit};
                r_done <= (r_cnt == CNW'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ rtl/core/alb_ring.sv @@
// Sample ring memory with running total, write slot and fill count.
// Depends on alb_pkg for the sample width.
`default_nettype none

module alb_ring
    import alb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic [SAMPLE_W-1:0]                    i_sample,
    output logic                                        o_done,
    output logic [SAMPLE_W+$clog2(DEPTH+1)-1:0]         o_total,
    output logic [$clog2(DEPTH+1)-1:0]                  o_fill
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = SAMPLE_W + CW;
    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rd;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SW-1:0]       r_slot;
    logic [CW-1:0]       r_fill;
    logic [TW-1:0]       r_total;
    logic                r_phase;
    logic                r_done;

    logic                n_full;
    logic [SAMPLE_W-1:0] n_old;

    // before the first wrap the slot has never been written, so it counts as zero
    always_comb begin
        n_full = (r_fill == CW'(DEPTH));
        n_old  = n_full ? r_rd : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rd     <= r_mem[r_slot];
            r_sample <= i_sample;
        end
        if (r_phase) begin
            r_mem[r_slot] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_fill  <= '0;
            r_total <= '0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= i_start;
            r_done  <= r_phase;
            if (r_phase) begin
                r_total <= r_total - TW'(n_old) + TW'(r_sample);
                if (!n_full) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (r_slot == SW'(DEPTH - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_total = r_total;
    assign o_fill  = r_fill;

endmodule

`default_nettype wire

@@ rtl/core/alb_apb_regs.sv @@
// APB register bank: full scale, step and base brightness.
// Depends on alb_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module alb_apb_regs
    import alb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx n_idx;
    logic     n_wr;

    always_comb begin
        n_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
        n_wr  = psel && penable && pwrite;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_scale <= FULL_SCALE_RESET;
            r_cfg.step       <= STEP_RESET;
            r_cfg.base       <= BASE_RESET;
        end else if (n_wr) begin
            unique case (n_idx)
                REG_FULL_SCALE: r_cfg.full_scale <= pwdata[SAMPLE_W-1:0];
                REG_STEP:       r_cfg.step       <= pwdata[STEP_W-1:0];
                REG_BASE:       r_cfg.base       <= pwdata[BRIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (n_idx)
            REG_FULL_SCALE: prdata = DATA_W'(r_cfg.full_scale);
            REG_STEP:       prdata = DATA_W'(r_cfg.step);
            REG_BASE:       prdata = DATA_W'(r_cfg.base);
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

`default_nettype wire

@@ rtl/core/ambient_light_brightness_filter.sv @@
// Top level of the ambient light brightness filter.
// Depends on alb_pkg, alb_apb_regs, alb_ring and alb_serial_div.
//
// Each accepted sample word goes into a ring of the last FILTER_DEPTH readings
// and gives one result word: the truncated mean, the display brightness
// (full_scale - mean) / step + base, saturated to 255 and never below base, and
// a flag set when the brightness differs from the previous result. One word is
// processed at a time, through the ring update and then the shared bit-serial
// divider, which runs once for the mean and once for the scaling. A new sample
// may be accepted while the previous result is still stalled in the output
// register. The ring is cleared at reset through the fill count, so no clearing
// pass is needed. Registers are to be written over APB only while idle; the
// block itself does not enforce this.
`default_nettype none

module ambient_light_brightness_filter
    import alb_pkg::*;
#(
    parameter int FILTER_DEPTH = DEPTH_DEFAULT,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [SAMPLE_W-1:0] i_sample_mv,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [SAMPLE_W-1:0]      o_average_mv,
    output logic [BRIGHT_W-1:0]      o_brightness,
    output logic                     o_brightness_changed,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    localparam int CW = $clog2(FILTER_DEPTH + 1);
    localparam int TW = SAMPLE_W + CW;
    localparam int DW = (CW > STEP_W) ? CW : STEP_W;
    localparam logic [SAMPLE_W-1:0] SMASK = (SAMPLE_BITS >= SAMPLE_W) ? '1 :
        SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RING,
        S_AVG,
        S_SCALE,
        S_OUT
    } t_state;

    t_state r_state;
    t_cfg   cfg;

    logic                ring_start;
    logic                ring_done;
    logic [TW-1:0]       ring_total;
    logic [CW-1:0]       ring_fill;

    logic                div_start;
    logic                div_done;
    logic [TW-1:0]       div_dividend;
    logic [DW-1:0]       div_divisor;
    logic [TW-1:0]       div_quot;

    logic [SAMPLE_W-1:0] r_avg;
    logic [BRIGHT_W-1:0] r_bright;
    logic [BRIGHT_W-1:0] r_last;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_avg;
    logic [BRIGHT_W-1:0] r_out_bright;
    logic                r_out_changed;

    logic [SAMPLE_W-1:0] n_diff;
    logic [BRIGHT_W:0]   n_sum;
    logic [BRIGHT_W-1:0] n_bright;
    logic                n_out_load;

    alb_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    alb_ring #(
        .DEPTH (FILTER_DEPTH)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ring_start),
        .i_sample (i_sample_mv & SMASK),
        .o_done   (ring_done),
        .o_total  (ring_total),
        .o_fill   (ring_fill)
    );

    alb_serial_div #(
        .W  (TW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        o_stall    = !i_rst_n || (r_state != S_IDLE);
        ring_start = i_valid && !o_stall;
        div_start  = ((r_state == S_RING) && ring_done) || ((r_state == S_AVG) && div_done);
        n_out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);

        n_diff = (cfg.full_scale > div_quot[SAMPLE_W-1:0]) ?
                 (cfg.full_scale - div_quot[SAMPLE_W-1:0]) : '0;

        if (r_state == S_RING) begin
            div_dividend = ring_total;
            div_divisor  = DW'(ring_fill);
        end else begin
            div_dividend = TW'(n_diff);
            div_divisor  = DW'(cfg.step);
        end

        n_sum    = {1'b0, div_quot[BRIGHT_W-1:0]} + {1'b0, cfg.base};
        n_bright = ((|div_quot[TW-1:BRIGHT_W]) || n_sum[BRIGHT_W]) ? '1 : n_sum[BRIGHT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= BASE_RESET;
        end else begin
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (ring_start) begin
                        r_state <= S_RING;
                    end
                end
                S_RING: begin
                    if (ring_done) begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (div_done) begin
                        r_avg   <= div_quot[SAMPLE_W-1:0];
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (div_done) begin
                        r_bright <= n_bright;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (n_out_load) begin
                        r_out_avg     <= r_avg;
                        r_out_bright  <= r_bright;
                        r_out_changed <= (r_bright != r_last);
                        r_last        <= r_bright;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid              = r_out_valid;
    assign o_average_mv         = r_out_avg;
    assign o_brightness         = r_out_bright;
    assign o_brightness_changed = r_out_changed;

endmodule

`default_nettype wire

@@ rtl/core/alb_checker.sv @@
// Port-level checker for the ambient light brightness filter, with its bind.
// Depends on alb_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module alb_checker
    import alb_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [SAMPLE_W-1:0] o_average_mv,
    input wire logic [BRIGHT_W-1:0] o_brightness,
    input wire logic                o_brightness_changed
);

    logic [SAMPLE_W+BRIGHT_W:0] res_word;

    assign res_word = {o_average_mv, o_brightness, o_brightness_changed};

    `ASSERT_ALWAYS(a_idle_after_reset, !i_rst_n ##1 i_rst_n |-> !o_valid && !o_stall, "busy after reset")
    `ASSERT_CLK(a_busy_after_accept, i_valid && !o_stall |=> o_stall, "second word taken while busy")
    `ASSERT_CLK(a_hold_valid, o_valid && i_stall |=> o_valid, "stalled result dropped")
    `ASSERT_CLK(a_hold_data, o_valid && i_stall |=> $stable(res_word), "stalled result changed")

endmodule

bind ambient_light_brightness_filter alb_checker u_alb_checker (.*);

`default_nettype wire

@@ dv/ambient_light_brightness_filter_tb.sv @@
// Self-checking bench for ambient_light_brightness_filter: sample words with bursty gaps,
// stalled results, APB register phases, and results checked against an in-bench predictor.
// Depends on alb_pkg and the filter RTL only.
module ambient_light_brightness_filter_tb;
    import alb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH   = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 60;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average_mv;
        logic [BRIGHT_W-1:0] brightness;
        logic                changed;
    } t_lux_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [SAMPLE_W-1:0] i_sample_mv = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [SAMPLE_W-1:0] o_average_mv;
    logic [BRIGHT_W-1:0] o_brightness;
    logic                o_brightness_changed;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // predictor state
    t_cfg                shadow_cfg = '{full_scale: FULL_SCALE_RESET, step: STEP_RESET,
                                        base: BASE_RESET};
    logic [SAMPLE_W-1:0] sample_ring [RING_DEPTH];
    logic [3:0]          write_slot = '0;
    logic [4:0]          fill_count = '0;
    logic [15:0]         running_total = '0;
    logic [BRIGHT_W-1:0] prev_brightness = BASE_RESET;

    logic [SAMPLE_W-1:0] sample_backlog [$];
    t_lux_result         awaited_results [$];

    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_run = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    ambient_light_brightness_filter uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_sample_mv         (i_sample_mv),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_average_mv        (o_average_mv),
        .o_brightness        (o_brightness),
        .o_brightness_changed(o_brightness_changed),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("[ambient_light_brightness_filter] ERROR");
        $finish;
    end

    function automatic t_lux_result smooth_sample(logic [SAMPLE_W-1:0] sample);
        int unsigned avg;
        int unsigned diff;
        int unsigned quot;
        int unsigned bright;
        t_lux_result r;
        running_total = running_total - sample_ring[write_slot] + sample;
        sample_ring[write_slot] = sample;
        if (fill_count < RING_DEPTH) fill_count = fill_count + 1;
        write_slot = (write_slot == RING_DEPTH - 1) ? '0 : write_slot + 1;
        avg = running_total / fill_count;
        diff = (shadow_cfg.full_scale > avg) ? shadow_cfg.full_scale - avg : 0;
        quot = (shadow_cfg.step == 0) ? 32'hFFFF_FFFF : diff / shadow_cfg.step;
        if (quot >= 255 || quot + shadow_cfg.base > 255) bright = 255;
        else bright = quot + shadow_cfg.base;
        r.average_mv = avg[SAMPLE_W-1:0];
        r.brightness = bright[BRIGHT_W-1:0];
        r.changed    = (bright[BRIGHT_W-1:0] != prev_brightness);
        prev_brightness = bright[BRIGHT_W-1:0];
        return r;
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= 10) $display("mismatch: %s", msg);
    endtask

    // sender: bursts of words with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) awaited_results.push_back(smooth_sample(i_sample_mv));
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (sample_backlog.size() != 0) begin
                    i_valid     <= 1'b1;
                    i_sample_mv <= sample_backlog.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks result words, stalls in modes of random length
    always @(posedge i_clk) begin
        t_lux_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                flag_error($sformatf("unexpected word avg=%0d bright=%0d chg=%0b",
                                     o_average_mv, o_brightness, o_brightness_changed));
            end else begin
                exp_r = awaited_results.pop_front();
                if (o_average_mv !== exp_r.average_mv || o_brightness !== exp_r.brightness
                    || o_brightness_changed !== exp_r.changed)
                    flag_error($sformatf("exp avg=%0d bright=%0d chg=%0b, got %0d %0d %0b",
                                         exp_r.average_mv, exp_r.brightness, exp_r.changed,
                                         o_average_mv, o_brightness, o_brightness_changed));
            end
        end
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_run  <= $urandom_range(10, 150);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= $urandom_range(0, 1);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic wait_drained();
        while (sample_backlog.size() != 0 || awaited_results.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] field_mask;
        field_mask = (idx == REG_BASE) ? 32'hFF : 32'hFFF;
        word = ($urandom & ~field_mask) | (value & field_mask);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FULL_SCALE: shadow_cfg.full_scale = word[SAMPLE_W-1:0];
            REG_STEP:       shadow_cfg.step = word[STEP_W-1:0];
            REG_BASE:       shadow_cfg.base = word[BRIGHT_W-1:0];
            default: ;
        endcase
    endtask

    initial begin
        int unsigned sent;
        int unsigned count;
        int unsigned style;
        int unsigned level;
        int unsigned val;
        foreach (sample_ring[k]) sample_ring[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // base moved before the first word: previous brightness keeps its reset value
        write_reg(REG_BASE, 200);
        sample_backlog = '{12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd4095, 12'd4095};
        wait_drained();
        // readings above full scale
        write_reg(REG_FULL_SCALE, 0);
        sample_backlog = '{12'd2000, 12'd0, 12'd4095};
        wait_drained();
        // saturation at 255
        write_reg(REG_FULL_SCALE, 4095);
        write_reg(REG_STEP, 1);
        write_reg(REG_BASE, 255);
        sample_backlog = '{12'd0, 12'd100, 12'd4095};
        wait_drained();
        // zero step, plus a write past the register list
        write_reg(REG_STEP, 0);
        write_reg(3, 32'h0000_0ABC);
        sample_backlog = '{12'd1234, 12'd0};
        wait_drained();
        write_reg(REG_STEP, 4095);
        write_reg(REG_BASE, 0);
        sample_backlog = '{12'd0, 12'd4095};
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 3))
                    0: val = 0;
                    1: val = 4095;
                    default: val = $urandom_range(0, 4095);
                endcase
                write_reg(REG_FULL_SCALE, val);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0: val = 0;
                    1: val = 1;
                    2: val = 4095;
                    3: val = $urandom_range(0, 4095);
                    default: val = $urandom_range(1, 64);
                endcase
                write_reg(REG_STEP, val);
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 3))
                    0: val = 0;
                    1: val = 255;
                    default: val = $urandom_range(0, 255);
                endcase
                write_reg(REG_BASE, val);
            end
            if ($urandom_range(0, 9) == 0) write_reg($urandom_range(3, 3), $urandom);

            count = $urandom_range(30, 70);
            style = $urandom_range(0, 3);
            level = $urandom_range(0, 4095);
            repeat (count) begin
                case (style)
                    0: val = level + $urandom_range(0, 8);
                    1: val = $urandom_range(0, 4095);
                    2: val = $urandom_range(0, 1) ? 4095 : 0;
                    default: begin
                        level = level + $urandom_range(0, 120);
                        val = level;
                    end
                endcase
                sample_backlog.push_back(val > 4095 ? 12'd4095 : val[SAMPLE_W-1:0]);
            end
            sent += count;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (awaited_results.size() != 0) flag_error("results still outstanding at end");
        if (error_count == 0) begin
            $display("[ambient_light_brightness_filter] OK");
        end else begin
            $display("[ambient_light_brightness_filter] ERROR");
        end
        $finish;
    end

endmodule
